/* rtl/dcg_pkg.sv */
package dcg_pkg;

  // Field and datapath widths
  localparam int TIME_W    = 48;
  localparam int AVG_W     = 48;
  localparam int SUM_W     = 48;
  localparam int CNT_W     = 16;
  localparam int BYTE_W    = 24;
  localparam int CYC_W     = 32;
  localparam int CLK_W     = 40;
  localparam int FT_W      = 24;
  localparam int WGT_W     = 17;
  localparam int CFG_W     = 24;

  // Shared multiply-accumulate unit: 48 x 16 per beat into a wide accumulator
  localparam int MUL_A_W   = 48;
  localparam int MUL_B_W   = 16;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = 128;
  localparam int SH_W      = 3;

  // Shared restoring divider: one quotient bit per cycle
  localparam int DIV_W     = 45;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_CPB = 6'd45;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_CLK = 6'd40;

  // cycles * 65536 / (bytes * 8) == cycles * 8192 / bytes
  localparam int CPB_SHIFT = 13;

  localparam logic [CNT_W-1:0] SAMPLE_THRESHOLD = 16'd16;
  localparam logic [FT_W-1:0]  FT_DEFAULT       = 24'd100000;
  localparam logic [FT_W-1:0]  FT_LIMIT         = 24'd10000000;
  localparam logic [WGT_W-1:0] WGT_RESET        = 17'd6554;
  localparam logic [WGT_W-1:0] WGT_ONE          = 17'd65536;

  // 1.2e6 split into two 16-bit digits
  localparam logic [MUL_B_W-1:0] CLK_C_LO = 16'h4F80;
  localparam logic [MUL_B_W-1:0] CLK_C_HI = 16'h0012;

  // Configuration register indexes
  localparam logic CFG_FRAME_TIME = 1'b0;
  localparam logic CFG_EMA_WEIGHT = 1'b1;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_COMMIT = 2'd1,
    OP_START  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_SAMPLED  = 3'd0,
    ST_ZERO_LEN = 3'd1,
    ST_FEW      = 3'd2,
    ST_REJECTED = 3'd3,
    ST_APPLIED  = 3'd4,
    ST_STARTED  = 3'd5
  } status_t;

  typedef struct packed {
    logic               en;
    logic               clr;
    logic [SH_W-1:0]    sh;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mac_req_t;

  typedef struct packed {
    logic [TIME_W-1:0]    rem;
    logic [DIV_W-1:0]     num;
    logic [TIME_W-1:0]    den;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

endpackage

/* rtl/dcg_mac.sv */
module dcg_mac (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dcg_pkg::mac_req_t          req,
  output logic                       pend,
  output logic [dcg_pkg::ACC_W-1:0]  acc
);
  import dcg_pkg::*;

  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [SH_W-1:0]   sh_r;
  logic              clr_r;
  logic              vld_r;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [ACC_W-1:0]  prod_ext;
  logic [ACC_W-1:0]  prod_sh;
  logic [SH_W+3:0]   shamt;

  // Product stage
  assign prod_nxt = PROD_W'(req.a) * PROD_W'(req.b);

  // Accumulate stage: add the shifted product, or restart from it
  assign shamt    = {sh_r, 4'b0000};
  assign prod_ext = {{(ACC_W-PROD_W){1'b0}}, prod_r};
  assign prod_sh  = prod_ext << shamt;

  always_comb begin
    acc_nxt = acc_r;
    if (vld_r) begin
      acc_nxt = (clr_r ? '0 : acc_r) + prod_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= req.en;
    end
    if (req.en) begin
      prod_r <= prod_nxt;
      sh_r   <= req.sh;
      clr_r  <= req.clr;
    end
    acc_r <= acc_nxt;
  end

  assign pend = vld_r;
  assign acc  = acc_r;

endmodule

/* rtl/dcg_div.sv */
module dcg_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  dcg_pkg::div_req_t         req,
  output logic                      busy,
  output logic [dcg_pkg::DIV_W-1:0] quo
);
  import dcg_pkg::*;

  logic [TIME_W-1:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]     num_r, num_nxt;
  logic [TIME_W-1:0]    den_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [TIME_W:0]      rem_sh;
  logic [TIME_W:0]      diff;
  logic                 ge;

  // One restoring step: shift in the next numerator bit, subtract if it fits
  assign rem_sh = {rem_r, num_r[DIV_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = (rem_sh >= {1'b0, den_r});

  always_comb begin
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = req.rem;
      num_nxt  = req.num;
      cnt_nxt  = req.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
      num_nxt = {num_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    if (start) begin
      den_r <= req.den;
    end
  end

  assign busy = busy_r;
  assign quo  = num_r;

endmodule

/* rtl/decode_clock_governor_unit.sv */
// Decoder clock governor. Sample beats fold each frame's decode cycles per bit
// (Q.16) into an exponential average and add the frame's bits to a window sum;
// commit beats check the window for stalls and return the new decoder clock in
// Hz (saturating at 2^40-1); start beats open a new window. Every beat gives one
// result beat. One item is in flight at a time: in_ready is high only while the
// block is idle, and a finished result waits in an output register. A sample
// runs the shared restoring divider (45 quotient bits for cycles per bit) and,
// when the average is blended, the shared 48x16 multiply-accumulate unit; a
// commit runs the multiply-accumulate unit for the stall test and, when applied,
// for the clock product, then the divider (40 quotient bits) unless the clock
// saturates. Zero-length, too-few-samples, zero-elapsed, start and unused-op
// beats use neither unit. in_ready returns in the cycle the result is
// registered; a result held by out_ready delays that by the length of the stall.
// Configuration writes take effect at once and must be issued while idle.
module decode_clock_governor_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [dcg_pkg::CFG_W-1:0]   cfg_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_op,
  input  logic [dcg_pkg::BYTE_W-1:0]  in_byte_count,
  input  logic [dcg_pkg::CYC_W-1:0]   in_decode_cycles,
  input  logic [dcg_pkg::TIME_W-1:0]  in_now_us,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_status,
  output logic [dcg_pkg::CLK_W-1:0]   out_clock_hz
);
  import dcg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CPB_DIV,
    S_EMA_MUL1,
    S_EMA_WAIT,
    S_WIN_WAIT,
    S_P_MUL,
    S_P_WAIT,
    S_N_MUL,
    S_N_WAIT,
    S_CLK_DIV,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [BYTE_W-1:0]   bytes_r, bytes_nxt;
  logic [CYC_W-1:0]    cycles_r, cycles_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [TIME_W-1:0]   elapsed_r, elapsed_nxt;
  logic [FT_W-1:0]     ft_r, ft_nxt;
  logic [WGT_W-1:0]    wgt_r, wgt_nxt;
  logic [AVG_W-1:0]    avg_r, avg_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    scnt_r, scnt_nxt;
  logic [TIME_W-1:0]   wstart_r, wstart_nxt;
  logic [TIME_W-1:0]   last_r, last_nxt;
  logic [2*AVG_W-1:0]  p_r, p_nxt;
  logic [1:0]          iss_r, iss_nxt;
  status_t             status_r, status_nxt;
  logic [CLK_W-1:0]    clock_r, clock_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [CLK_W-1:0]    out_clock_r, out_clock_nxt;

  mac_req_t            mac_req;
  logic                mac_pend;
  logic [ACC_W-1:0]    acc;
  logic                div_start;
  div_req_t            div_req;
  logic                div_busy;
  logic [DIV_W-1:0]    quo;

  logic                in_accept;
  logic [FT_W-1:0]     ft_eff;
  logic [FT_W+1:0]     m_sum;
  logic [FT_W:0]       m_val;
  logic [SUM_W:0]      sum_add;
  logic [SUM_W-1:0]    sum_sat;
  logic [CNT_W-1:0]    scnt_inc;
  logic [TIME_W+1:0]   e2;
  logic [TIME_W+1:0]   l3;
  logic                win_ok;
  logic                clk_sat;
  logic                ema_direct;
  logic [WGT_W-1:0]    wgt_inv;

  dcg_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .pend  (mac_pend),
    .acc   (acc)
  );

  dcg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .req   (div_req),
    .busy  (div_busy),
    .quo   (quo)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;

  // Frame time with the 10 Hz fallback
  assign ft_eff = ((ft_r == '0) || (ft_r > FT_LIMIT)) ? FT_DEFAULT : ft_r;

  // 2*floor(e/n) < 3*ft  <=>  e < n * floor((3*ft+1)/2)
  assign m_sum = {2'b00, ft_eff} + {1'b0, ft_eff, 1'b0} + (FT_W+2)'(1);
  assign m_val = m_sum[FT_W+1:1];

  // Window sum and sample count, both saturating
  assign sum_add  = {1'b0, sum_r} + {{(SUM_W-BYTE_W-2){1'b0}}, bytes_r, 3'b000};
  assign sum_sat  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign scnt_inc = (scnt_r == '1) ? scnt_r : scnt_r + 1'b1;

  // Stall test, product n*M sits in the accumulator
  assign e2     = {1'b0, elapsed_r, 1'b0};
  assign l3     = {2'b00, last_r} + {1'b0, last_r, 1'b0};
  assign win_ok = ({8'b0, acc[39:0]} > elapsed_r) || ((last_r != '0) && (e2 < l3));

  // Quotient would not fit in 40 bits
  assign clk_sat = (acc[ACC_W-1:56] >= {{(ACC_W-56-TIME_W){1'b0}}, elapsed_r});

  assign ema_direct = (avg_r == '0) || wgt_r[WGT_W-1];
  assign wgt_inv    = WGT_ONE - wgt_r;

  // Sequencer and datapath next state
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    bytes_nxt      = bytes_r;
    cycles_nxt     = cycles_r;
    now_nxt        = now_r;
    elapsed_nxt    = elapsed_r;
    ft_nxt         = ft_r;
    wgt_nxt        = wgt_r;
    avg_nxt        = avg_r;
    sum_nxt        = sum_r;
    scnt_nxt       = scnt_r;
    wstart_nxt     = wstart_r;
    last_nxt       = last_r;
    p_nxt          = p_r;
    iss_nxt        = iss_r;
    status_nxt     = status_r;
    clock_nxt      = clock_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_clock_nxt  = out_clock_r;
    mac_req        = '0;
    div_start      = 1'b0;
    div_req        = '0;

    // Configuration writes
    if (cfg_we) begin
      if (cfg_index == CFG_FRAME_TIME) begin
        ft_nxt = cfg_data[FT_W-1:0];
      end else begin
        wgt_nxt = cfg_data[WGT_W-1:0];
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt      = op_t'(in_op);
          bytes_nxt   = in_byte_count;
          cycles_nxt  = in_decode_cycles;
          now_nxt     = in_now_us;
          elapsed_nxt = in_now_us - wstart_r;
          state_nxt   = S_DECODE;
        end
      end

      S_DECODE: begin
        clock_nxt  = '0;
        status_nxt = ST_REJECTED;
        state_nxt  = S_DONE;
        unique case (op_r)
          OP_SAMPLE: begin
            if (bytes_r == '0) begin
              status_nxt = ST_ZERO_LEN;
            end else begin
              div_start     = 1'b1;
              div_req.rem   = '0;
              div_req.num   = {cycles_r, {CPB_SHIFT{1'b0}}};
              div_req.den   = {{(TIME_W-BYTE_W){1'b0}}, bytes_r};
              div_req.steps = DIV_STEPS_CPB;
              state_nxt     = S_CPB_DIV;
            end
          end
          OP_COMMIT: begin
            if (scnt_r < SAMPLE_THRESHOLD) begin
              status_nxt = ST_FEW;
            end else if (elapsed_r == '0) begin
              sum_nxt    = '0;
              scnt_nxt   = '0;
              wstart_nxt = now_r;
            end else begin
              mac_req.en  = 1'b1;
              mac_req.clr = 1'b1;
              mac_req.sh  = '0;
              mac_req.a   = {{(MUL_A_W-FT_W-1){1'b0}}, m_val};
              mac_req.b   = scnt_r;
              state_nxt   = S_WIN_WAIT;
            end
          end
          OP_START: begin
            sum_nxt    = '0;
            scnt_nxt   = '0;
            wstart_nxt = now_r;
            status_nxt = ST_STARTED;
          end
          default: begin
            status_nxt = ST_REJECTED;
          end
        endcase
      end

      // cycles per bit ready: seed, take over, keep, or blend the average
      S_CPB_DIV: begin
        if (!div_busy) begin
          if (ema_direct || (wgt_r == '0)) begin
            if (ema_direct) begin
              avg_nxt = {{(AVG_W-DIV_W){1'b0}}, quo};
            end
            sum_nxt    = sum_sat;
            scnt_nxt   = scnt_inc;
            status_nxt = ST_SAMPLED;
            state_nxt  = S_DONE;
          end else begin
            mac_req.en  = 1'b1;
            mac_req.clr = 1'b1;
            mac_req.sh  = '0;
            mac_req.a   = {{(MUL_A_W-DIV_W){1'b0}}, quo};
            mac_req.b   = wgt_r[MUL_B_W-1:0];
            state_nxt   = S_EMA_MUL1;
          end
        end
      end

      S_EMA_MUL1: begin
        mac_req.en  = 1'b1;
        mac_req.clr = 1'b0;
        mac_req.sh  = '0;
        mac_req.a   = avg_r;
        mac_req.b   = wgt_inv[MUL_B_W-1:0];
        state_nxt   = S_EMA_WAIT;
      end

      S_EMA_WAIT: begin
        if (!mac_pend) begin
          avg_nxt    = acc[AVG_W+15:16];
          sum_nxt    = sum_sat;
          scnt_nxt   = scnt_inc;
          status_nxt = ST_SAMPLED;
          state_nxt  = S_DONE;
        end
      end

      S_WIN_WAIT: begin
        if (!mac_pend) begin
          if (win_ok) begin
            iss_nxt   = '0;
            state_nxt = S_P_MUL;
          end else begin
            sum_nxt    = '0;
            scnt_nxt   = '0;
            wstart_nxt = now_r;
            status_nxt = ST_REJECTED;
            state_nxt  = S_DONE;
          end
        end
      end

      // avg * bit_sum, one 16-bit digit of the sum per beat
      S_P_MUL: begin
        mac_req.en  = 1'b1;
        mac_req.clr = (iss_r == 2'd0);
        mac_req.sh  = {1'b0, iss_r};
        mac_req.a   = avg_r;
        mac_req.b   = sum_r[{iss_r, 4'b0000} +: MUL_B_W];
        iss_nxt     = iss_r + 1'b1;
        if (iss_r == 2'd2) begin
          state_nxt = S_P_WAIT;
        end
      end

      S_P_WAIT: begin
        if (!mac_pend) begin
          p_nxt     = acc[2*AVG_W-1:0];
          iss_nxt   = '0;
          state_nxt = S_N_MUL;
        end
      end

      // product * 1.2e6 as four partial products
      S_N_MUL: begin
        mac_req.en  = 1'b1;
        mac_req.clr = (iss_r == 2'd0);
        unique case (iss_r)
          2'd0: begin
            mac_req.sh = 3'd0;
            mac_req.a  = p_r[AVG_W-1:0];
            mac_req.b  = CLK_C_LO;
          end
          2'd1: begin
            mac_req.sh = 3'd1;
            mac_req.a  = p_r[AVG_W-1:0];
            mac_req.b  = CLK_C_HI;
          end
          2'd2: begin
            mac_req.sh = 3'd3;
            mac_req.a  = p_r[2*AVG_W-1:AVG_W];
            mac_req.b  = CLK_C_LO;
          end
          default: begin
            mac_req.sh = 3'd4;
            mac_req.a  = p_r[2*AVG_W-1:AVG_W];
            mac_req.b  = CLK_C_HI;
          end
        endcase
        iss_nxt = iss_r + 1'b1;
        if (iss_r == 2'd3) begin
          state_nxt = S_N_WAIT;
        end
      end

      // floor(N / (e*65536)) == floor((N >> 16) / e)
      S_N_WAIT: begin
        if (!mac_pend) begin
          if (clk_sat) begin
            clock_nxt  = '1;
            last_nxt   = elapsed_r;
            sum_nxt    = '0;
            scnt_nxt   = '0;
            wstart_nxt = now_r;
            status_nxt = ST_APPLIED;
            state_nxt  = S_DONE;
          end else begin
            div_start     = 1'b1;
            div_req.rem   = acc[103:56];
            div_req.num   = {acc[55:16], {(DIV_W-CLK_W){1'b0}}};
            div_req.den   = elapsed_r;
            div_req.steps = DIV_STEPS_CLK;
            state_nxt     = S_CLK_DIV;
          end
        end
      end

      S_CLK_DIV: begin
        if (!div_busy) begin
          clock_nxt  = quo[CLK_W-1:0];
          last_nxt   = elapsed_r;
          sum_nxt    = '0;
          scnt_nxt   = '0;
          wstart_nxt = now_r;
          status_nxt = ST_APPLIED;
          state_nxt  = S_DONE;
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_clock_nxt  = clock_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ft_r        <= FT_DEFAULT;
      wgt_r       <= WGT_RESET;
      avg_r       <= '0;
      sum_r       <= '0;
      scnt_r      <= '0;
      wstart_r    <= '0;
      last_r      <= '0;
      iss_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      bytes_r      <= bytes_nxt;
      cycles_r     <= cycles_nxt;
      now_r        <= now_nxt;
      elapsed_r    <= elapsed_nxt;
      ft_r         <= ft_nxt;
      wgt_r        <= wgt_nxt;
      avg_r        <= avg_nxt;
      sum_r        <= sum_nxt;
      scnt_r       <= scnt_nxt;
      wstart_r     <= wstart_nxt;
      last_r       <= last_nxt;
      p_r          <= p_nxt;
      iss_r        <= iss_nxt;
      status_r     <= status_nxt;
      clock_r      <= clock_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_clock_r  <= out_clock_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_clock_hz = out_clock_r;

`ifndef SYNTHESIS
  // multiplier and divider are never both in use
  a_unit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mac_req.en && div_busy))
    else $error("mac issued while divider busy");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (!div_busy && !mac_pend))
    else $error("divider started while a unit is busy");

  a_clk_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_APPLIED)) |-> (out_clock_r == '0))
    else $error("clock value on a non-applied result");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside the done state");

  a_scnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(scnt_r) |-> ((scnt_r == $past(scnt_r) + 16'd1) || (scnt_r == '0)))
    else $error("sample count jumped");
`endif

endmodule
